/* rtl/core/bmhq_pkg.sv */
`timescale 1ns / 1ps

package bmhq_pkg;

  localparam int DefCapacity = 128;

  localparam int KeyW    = 64;
  localparam int NightsW = 16;
  localparam int GuestsW = 3;
  localparam int RoomsW  = 8;
  localparam int PriceW  = 32;
  localparam int PosW    = 7;
  localparam int FillW   = 8;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_EXTRACT = 2'd1,
    OP_DELETE  = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_EMPTY  = 2'd1,
    STAT_FULL   = 2'd2,
    STAT_BADPOS = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EX_ROOT,
    ST_LAST,
    ST_DN_L,
    ST_DN_R,
    ST_DN_CMP,
    ST_UP_RD,
    ST_UP_CMP,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [KeyW-1:0]    key;
    logic [NightsW-1:0] nights;
    logic [GuestsW-1:0] guests;
    logic [RoomsW-1:0]  rooms;
    logic [PriceW-1:0]  price;
  } rec_t;

endpackage

/* rtl/core/binary_min_heap_queue.sv */
`timescale 1ns / 1ps

// Binary min-heap priority queue of records (64-bit key plus payload).
// The input channel takes one item per operation: insert, extract minimum
// or delete at a heap position. Each item produces exactly one result item
// carrying a status, the extracted record (zero for anything but a good
// extract) and the fill count after the operation.
// The block works on one item at a time. in_stall_o is high while an item
// is being processed. Errors and no-op codes go straight to the result.
// Insert climbs the heap level by level; extract and delete descend it,
// and a delete that does not move down may climb instead. Each step is
// paced by the single read port of the record memory, whose read data is
// registered. The next item is taken once the result has been loaded into
// the output register.
// The result waits in an output register; while the receiver stalls, the
// finished result holds and the next item is not started past its final
// write. Reset empties the heap at once (only the entry count is cleared);
// the record memory is not cleared.
module binary_min_heap_queue #(
  parameter int CAPACITY = bmhq_pkg::DefCapacity
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   op_i,
  input  logic [bmhq_pkg::KeyW-1:0]    entry_key_i,
  input  logic [bmhq_pkg::NightsW-1:0] entry_nights_i,
  input  logic [bmhq_pkg::GuestsW-1:0] entry_guests_i,
  input  logic [bmhq_pkg::RoomsW-1:0]  entry_rooms_i,
  input  logic [bmhq_pkg::PriceW-1:0]  entry_price_i,
  input  logic [bmhq_pkg::PosW-1:0]    position_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   status_o,
  output logic [bmhq_pkg::KeyW-1:0]    out_key_o,
  output logic [bmhq_pkg::NightsW-1:0] out_nights_o,
  output logic [bmhq_pkg::GuestsW-1:0] out_guests_o,
  output logic [bmhq_pkg::RoomsW-1:0]  out_rooms_o,
  output logic [bmhq_pkg::PriceW-1:0]  out_price_o,
  output logic [bmhq_pkg::FillW-1:0]   fill_count_o
);

  localparam int AW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int IW  = AW + 2;
  localparam int PCW = (CW > bmhq_pkg::PosW) ? CW : bmhq_pkg::PosW;
  localparam int FW  = bmhq_pkg::FillW;

  bmhq_pkg::rec_t mem [CAPACITY];
  bmhq_pkg::rec_t rd_data_q;
  logic           rd_en, wr_en;
  logic [AW-1:0]  rd_addr, wr_addr;
  bmhq_pkg::rec_t wr_data;

  bmhq_pkg::state_e  state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic              out_valid_q, out_valid_d;
  logic              load_out;

  bmhq_pkg::op_e     op_q, op_d;
  bmhq_pkg::status_e stat_q, stat_d;
  logic [AW-1:0]     idx_q, idx_d;
  bmhq_pkg::rec_t    rec_q, rec_d;
  bmhq_pkg::rec_t    child_q, child_d;
  logic              child_take_q, child_take_d;
  logic              right_ok_q, right_ok_d;
  bmhq_pkg::rec_t    res_q, res_d;

  bmhq_pkg::status_e out_stat_q;
  bmhq_pkg::rec_t    out_rec_q;
  logic [FW-1:0]     out_fill_q;

  bmhq_pkg::rec_t    in_rec;
  bmhq_pkg::op_e     in_op;
  logic [PCW-1:0]    pos_ext, cnt_ext;
  logic [IW-1:0]     cnt_iw, left_w, right_w;
  logic [AW-1:0]     parent_w;
  logic [CW-1:0]     last_w;
  logic [CW+FW-1:0]  fill_wide;
  logic              take_right;

  assign in_rec = '{key: entry_key_i, nights: entry_nights_i, guests: entry_guests_i,
                    rooms: entry_rooms_i, price: entry_price_i};
  assign in_op   = bmhq_pkg::op_e'(op_i);
  assign pos_ext = PCW'(position_i);
  assign cnt_ext = PCW'(count_q);
  assign cnt_iw  = IW'(count_q);
  assign left_w  = (IW'(idx_q) << 1) + IW'(1);
  assign right_w = (IW'(idx_q) << 1) + IW'(2);
  assign parent_w = (idx_q - AW'(1)) >> 1;
  assign last_w  = count_q - CW'(1);
  assign take_right = right_ok_q &&
                      (rd_data_q.key < (child_take_q ? child_q.key : rec_q.key));
  assign fill_wide = {{FW{1'b0}}, count_q};

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    op_d         = op_q;
    stat_d       = stat_q;
    idx_d        = idx_q;
    rec_d        = rec_q;
    child_d      = child_q;
    child_take_d = child_take_q;
    right_ok_d   = right_ok_q;
    res_d        = res_q;
    rd_en        = 1'b0;
    rd_addr      = '0;
    wr_en        = 1'b0;
    wr_addr      = idx_q;
    wr_data      = rec_q;
    load_out     = 1'b0;

    unique case (state_q)
      bmhq_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          op_d   = in_op;
          stat_d = bmhq_pkg::STAT_OK;
          res_d  = '0;
          state_d = bmhq_pkg::ST_DONE;
          unique case (in_op)
            bmhq_pkg::OP_INSERT: begin
              if (count_q == CW'(CAPACITY)) begin
                stat_d = bmhq_pkg::STAT_FULL;
              end else begin
                rec_d   = in_rec;
                idx_d   = count_q[AW-1:0];
                count_d = count_q + CW'(1);
                state_d = bmhq_pkg::ST_UP_RD;
              end
            end
            bmhq_pkg::OP_EXTRACT: begin
              if (count_q == '0) begin
                stat_d = bmhq_pkg::STAT_EMPTY;
              end else begin
                rd_en   = 1'b1;
                rd_addr = '0;
                idx_d   = '0;
                count_d = last_w;
                state_d = bmhq_pkg::ST_EX_ROOT;
              end
            end
            bmhq_pkg::OP_DELETE: begin
              if (pos_ext >= cnt_ext) begin
                stat_d = bmhq_pkg::STAT_BADPOS;
              end else begin
                count_d = last_w;
                // Removing the last entry only shrinks the heap.
                if (pos_ext != PCW'(last_w)) begin
                  rd_en   = 1'b1;
                  rd_addr = last_w[AW-1:0];
                  idx_d   = pos_ext[AW-1:0];
                  state_d = bmhq_pkg::ST_LAST;
                end
              end
            end
            bmhq_pkg::OP_NONE: begin
              stat_d = bmhq_pkg::STAT_OK;
            end
            default: begin
              stat_d = bmhq_pkg::STAT_OK;
            end
          endcase
        end
      end
      bmhq_pkg::ST_EX_ROOT: begin
        res_d   = rd_data_q;
        // The count is already decremented, so it indexes the last entry.
        rd_en   = 1'b1;
        rd_addr = count_q[AW-1:0];
        state_d = bmhq_pkg::ST_LAST;
      end
      bmhq_pkg::ST_LAST: begin
        rec_d   = rd_data_q;
        state_d = bmhq_pkg::ST_DN_L;
      end
      bmhq_pkg::ST_DN_L: begin
        if (left_w < cnt_iw) begin
          rd_en   = 1'b1;
          rd_addr = left_w[AW-1:0];
          state_d = bmhq_pkg::ST_DN_R;
        end else if (op_q == bmhq_pkg::OP_DELETE) begin
          state_d = bmhq_pkg::ST_UP_RD;
        end else begin
          wr_en   = 1'b1;
          state_d = bmhq_pkg::ST_DONE;
        end
      end
      bmhq_pkg::ST_DN_R: begin
        child_d      = rd_data_q;
        child_take_d = rd_data_q.key < rec_q.key;
        right_ok_d   = right_w < cnt_iw;
        if (right_w < cnt_iw) begin
          rd_en   = 1'b1;
          rd_addr = right_w[AW-1:0];
        end
        state_d = bmhq_pkg::ST_DN_CMP;
      end
      bmhq_pkg::ST_DN_CMP: begin
        if (take_right) begin
          wr_en   = 1'b1;
          wr_data = rd_data_q;
          idx_d   = right_w[AW-1:0];
          state_d = bmhq_pkg::ST_DN_L;
        end else if (child_take_q) begin
          wr_en   = 1'b1;
          wr_data = child_q;
          idx_d   = left_w[AW-1:0];
          state_d = bmhq_pkg::ST_DN_L;
        end else if (op_q == bmhq_pkg::OP_DELETE) begin
          state_d = bmhq_pkg::ST_UP_RD;
        end else begin
          wr_en   = 1'b1;
          state_d = bmhq_pkg::ST_DONE;
        end
      end
      bmhq_pkg::ST_UP_RD: begin
        if (idx_q == '0) begin
          wr_en   = 1'b1;
          state_d = bmhq_pkg::ST_DONE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = parent_w;
          state_d = bmhq_pkg::ST_UP_CMP;
        end
      end
      bmhq_pkg::ST_UP_CMP: begin
        // Equal keys never move the record above its parent.
        if (rec_q.key < rd_data_q.key) begin
          wr_en   = 1'b1;
          wr_data = rd_data_q;
          idx_d   = parent_w;
          state_d = bmhq_pkg::ST_UP_RD;
        end else begin
          wr_en   = 1'b1;
          state_d = bmhq_pkg::ST_DONE;
        end
      end
      bmhq_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = bmhq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bmhq_pkg::ST_IDLE;
      end
    endcase

    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bmhq_pkg::ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    stat_q       <= stat_d;
    idx_q        <= idx_d;
    rec_q        <= rec_d;
    child_q      <= child_d;
    child_take_q <= child_take_d;
    right_ok_q   <= right_ok_d;
    res_q        <= res_d;
    if (load_out) begin
      out_stat_q <= stat_q;
      out_rec_q  <= res_q;
      out_fill_q <= fill_wide[FW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  assign in_stall_o   = (state_q != bmhq_pkg::ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign status_o     = out_stat_q;
  assign out_key_o    = out_rec_q.key;
  assign out_nights_o = out_rec_q.nights;
  assign out_guests_o = out_rec_q.guests;
  assign out_rooms_o  = out_rec_q.rooms;
  assign out_price_o  = out_rec_q.price;
  assign fill_count_o = out_fill_q;

endmodule

/* tb/heap_checker.sv */
`timescale 1ns / 1ps

module heap_checker #(
  parameter int CAPACITY = bmhq_pkg::DefCapacity
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic [1:0]                   op_i,
  input  logic [bmhq_pkg::KeyW-1:0]    entry_key_i,
  input  logic [bmhq_pkg::NightsW-1:0] entry_nights_i,
  input  logic [bmhq_pkg::GuestsW-1:0] entry_guests_i,
  input  logic [bmhq_pkg::RoomsW-1:0]  entry_rooms_i,
  input  logic [bmhq_pkg::PriceW-1:0]  entry_price_i,
  input  logic [bmhq_pkg::PosW-1:0]    position_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic [1:0]                   status_i,
  input  logic [bmhq_pkg::KeyW-1:0]    out_key_i,
  input  logic [bmhq_pkg::NightsW-1:0] out_nights_i,
  input  logic [bmhq_pkg::GuestsW-1:0] out_guests_i,
  input  logic [bmhq_pkg::RoomsW-1:0]  out_rooms_i,
  input  logic [bmhq_pkg::PriceW-1:0]  out_price_i,
  input  logic [bmhq_pkg::FillW-1:0]   fill_count_i,
  output int                           errors_o,
  output int                           pending_o
);

  typedef struct {
    bmhq_pkg::status_e          status;
    bmhq_pkg::rec_t             rec;
    logic [bmhq_pkg::FillW-1:0] fill;
  } outcome_t;

  bmhq_pkg::rec_t heap_rec [CAPACITY];
  int unsigned    heap_size;
  outcome_t       due_q [$];
  outcome_t       want;

  function automatic void swap_slots(int unsigned a, int unsigned b);
    bmhq_pkg::rec_t tmp;
    tmp         = heap_rec[a];
    heap_rec[a] = heap_rec[b];
    heap_rec[b] = tmp;
  endfunction

  // Returns the slot where the moved record came to rest.
  function automatic int unsigned sink(int unsigned idx);
    int unsigned lft, rgt, best;
    while (1) begin
      lft  = 2 * idx + 1;
      rgt  = 2 * idx + 2;
      best = idx;
      if (lft < heap_size && heap_rec[lft].key < heap_rec[best].key) best = lft;
      if (rgt < heap_size && heap_rec[rgt].key < heap_rec[best].key) best = rgt;
      if (best == idx) return idx;
      swap_slots(idx, best);
      idx = best;
    end
  endfunction

  function automatic void rise(int unsigned idx);
    int unsigned parent;
    while (idx > 0) begin
      parent = (idx - 1) / 2;
      if (!(heap_rec[idx].key < heap_rec[parent].key)) return;
      swap_slots(idx, parent);
      idx = parent;
    end
  endfunction

  function automatic outcome_t apply_op(bmhq_pkg::op_e op, bmhq_pkg::rec_t rec,
                                        logic [bmhq_pkg::PosW-1:0] pos);
    outcome_t res;
    res.status = bmhq_pkg::STAT_OK;
    res.rec    = '0;
    case (op)
      bmhq_pkg::OP_INSERT: begin
        if (heap_size >= CAPACITY) begin
          res.status = bmhq_pkg::STAT_FULL;
        end else begin
          heap_rec[heap_size] = rec;
          heap_size++;
          rise(heap_size - 1);
        end
      end
      bmhq_pkg::OP_EXTRACT: begin
        if (heap_size == 0) begin
          res.status = bmhq_pkg::STAT_EMPTY;
        end else begin
          res.rec = heap_rec[0];
          heap_size--;
          heap_rec[0] = heap_rec[heap_size];
          void'(sink(0));
        end
      end
      bmhq_pkg::OP_DELETE: begin
        if (pos >= heap_size) begin
          res.status = bmhq_pkg::STAT_BADPOS;
        end else begin
          heap_size--;
          // Removing the last slot only shrinks the heap.
          if (pos != heap_size) begin
            heap_rec[pos] = heap_rec[heap_size];
            rise(sink(pos));
          end
        end
      end
      default: ;
    endcase
    res.fill = heap_size[bmhq_pkg::FillW-1:0];
    return res;
  endfunction

  task automatic check_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %0h, got %0h", name, exp_val, act_val);
      errors_o++;
    end
  endtask

  // Results are compared before the item of the same edge is predicted, so
  // the order of the two channels within one edge never matters.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_size = 0;
      due_q.delete();
      pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (due_q.size() == 0) begin
          $error("result item arrived with no expected item waiting");
          errors_o++;
        end else begin
          want = due_q.pop_front();
          check_field("status", 64'(want.status), 64'(status_i));
          check_field("out_key", want.rec.key, out_key_i);
          check_field("out_nights", 64'(want.rec.nights), 64'(out_nights_i));
          check_field("out_guests", 64'(want.rec.guests), 64'(out_guests_i));
          check_field("out_rooms", 64'(want.rec.rooms), 64'(out_rooms_i));
          check_field("out_price", 64'(want.rec.price), 64'(out_price_i));
          check_field("fill_count", 64'(want.fill), 64'(fill_count_i));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        due_q.push_back(apply_op(bmhq_pkg::op_e'(op_i),
                                 {entry_key_i, entry_nights_i, entry_guests_i,
                                  entry_rooms_i, entry_price_i},
                                 position_i));
      end
      pending_o = due_q.size();
    end
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  localparam int Capacity   = bmhq_pkg::DefCapacity;
  localparam int TotalItems = 1650;
  localparam int CycleLimit = 600000;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic [1:0]                    op;
  logic [bmhq_pkg::KeyW-1:0]     entry_key;
  logic [bmhq_pkg::NightsW-1:0]  entry_nights;
  logic [bmhq_pkg::GuestsW-1:0]  entry_guests;
  logic [bmhq_pkg::RoomsW-1:0]   entry_rooms;
  logic [bmhq_pkg::PriceW-1:0]   entry_price;
  logic [bmhq_pkg::PosW-1:0]     position;
  logic                          out_valid;
  logic                          out_stall;
  logic [1:0]                    status;
  logic [bmhq_pkg::KeyW-1:0]     out_key;
  logic [bmhq_pkg::NightsW-1:0]  out_nights;
  logic [bmhq_pkg::GuestsW-1:0]  out_guests;
  logic [bmhq_pkg::RoomsW-1:0]   out_rooms;
  logic [bmhq_pkg::PriceW-1:0]   out_price;
  logic [bmhq_pkg::FillW-1:0]    fill_count;
  int                            errors;
  int                            pending;
  int                            cycles = 0;

  // Stimulus-side view of the fill level, used to steer the random mix and to pick delete positions.
  int                            level = 0;
  int                            items_sent = 0;
  int                            burst_left = 0;

  always #5 clk = ~clk;

  binary_min_heap_queue #(
    .CAPACITY (Capacity)
  ) i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .op_i           (op),
    .entry_key_i    (entry_key),
    .entry_nights_i (entry_nights),
    .entry_guests_i (entry_guests),
    .entry_rooms_i  (entry_rooms),
    .entry_price_i  (entry_price),
    .position_i     (position),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .status_o       (status),
    .out_key_o      (out_key),
    .out_nights_o   (out_nights),
    .out_guests_o   (out_guests),
    .out_rooms_o    (out_rooms),
    .out_price_o    (out_price),
    .fill_count_o   (fill_count)
  );

  heap_checker #(
    .CAPACITY (Capacity)
  ) i_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .op_i           (op),
    .entry_key_i    (entry_key),
    .entry_nights_i (entry_nights),
    .entry_guests_i (entry_guests),
    .entry_rooms_i  (entry_rooms),
    .entry_price_i  (entry_price),
    .position_i     (position),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .status_i       (status),
    .out_key_i      (out_key),
    .out_nights_i   (out_nights),
    .out_guests_i   (out_guests),
    .out_rooms_i    (out_rooms),
    .out_price_i    (out_price),
    .fill_count_i   (fill_count),
    .errors_o       (errors),
    .pending_o      (pending)
  );

  function automatic bmhq_pkg::rec_t random_stay();
    bmhq_pkg::rec_t rec;
    int unsigned    pick;
    pick = $urandom_range(0, 99);
    rec.nights = bmhq_pkg::NightsW'($urandom);
    rec.guests = bmhq_pkg::GuestsW'($urandom);
    rec.rooms  = bmhq_pkg::RoomsW'($urandom);
    rec.price  = $urandom;
    // Narrow keys give plenty of ties; wide keys exercise every key bit.
    if (pick < 50)      rec.key = {$urandom, $urandom};
    else if (pick < 85) rec.key = bmhq_pkg::KeyW'($urandom_range(0, 15));
    else if (pick < 92) rec.key = '0;
    else                rec.key = '1;
    return rec;
  endfunction

  task automatic send(bmhq_pkg::op_e code, bmhq_pkg::rec_t rec,
                      logic [bmhq_pkg::PosW-1:0] pos);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    op           <= code;
    entry_key    <= rec.key;
    entry_nights <= rec.nights;
    entry_guests <= rec.guests;
    entry_rooms  <= rec.rooms;
    entry_price  <= rec.price;
    position     <= pos;
    do @(posedge clk); while (in_stall);
    burst_left--;
    items_sent++;
    case (code)
      bmhq_pkg::OP_INSERT:  if (level < Capacity) level++;
      bmhq_pkg::OP_EXTRACT: if (level > 0) level--;
      bmhq_pkg::OP_DELETE:  if (pos < level) level--;
      default: ;
    endcase
  endtask

  // Holds the input channel quiet until every expected result has come back.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [bmhq_pkg::PosW-1:0] pick_position();
    if (level > 0 && $urandom_range(0, 99) < 85) begin
      return bmhq_pkg::PosW'($urandom_range(0, level - 1));
    end
    return bmhq_pkg::PosW'($urandom_range(0, 127));
  endfunction

  // Phase 0 is a balanced mix, phase 1 fills the heap, phase 2 empties it.
  function automatic bmhq_pkg::op_e pick_op(int phase);
    int unsigned r;
    r = $urandom_range(0, 99);
    case (phase)
      1:       return (r < 85) ? bmhq_pkg::OP_INSERT :
                      (r < 93) ? bmhq_pkg::OP_EXTRACT :
                      (r < 98) ? bmhq_pkg::OP_DELETE : bmhq_pkg::OP_NONE;
      2:       return (r < 65) ? bmhq_pkg::OP_EXTRACT :
                      (r < 92) ? bmhq_pkg::OP_DELETE :
                      (r < 98) ? bmhq_pkg::OP_INSERT : bmhq_pkg::OP_NONE;
      default: return (r < 45) ? bmhq_pkg::OP_INSERT :
                      (r < 72) ? bmhq_pkg::OP_EXTRACT :
                      (r < 95) ? bmhq_pkg::OP_DELETE : bmhq_pkg::OP_NONE;
    endcase
  endfunction

  // The receiver stalls in stretches of its own: never, at random, mostly,
  // or on a fixed rhythm.
  initial begin
    int mode;
    int span;
    int tick;
    out_stall = 1'b0;
    tick = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(negedge clk);
        tick++;
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= 1'($urandom_range(0, 1));
          2:       out_stall <= ($urandom_range(0, 9) < 8);
          default: out_stall <= tick[2];
        endcase
      end
    end
  end

  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    bmhq_pkg::rec_t stay;
    int             phase;
    int             span;
    int             round;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    op           = bmhq_pkg::OP_NONE;
    entry_key    = '0;
    entry_nights = '0;
    entry_guests = '0;
    entry_rooms  = '0;
    entry_price  = '0;
    position     = '0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty-heap errors, the unused code, extreme records, ties,
    // bad positions, removal of the last slot and of the root.
    send(bmhq_pkg::OP_EXTRACT, random_stay(), '0);
    send(bmhq_pkg::OP_DELETE, random_stay(), '0);
    send(bmhq_pkg::OP_NONE, random_stay(), '1);
    send(bmhq_pkg::OP_INSERT, '1, '0);
    send(bmhq_pkg::OP_INSERT, '0, '1);
    stay = {64'd5, 16'h1111, 3'd1, 8'h11, 32'h1111_1111};
    send(bmhq_pkg::OP_INSERT, stay, '0);
    stay = {64'd5, 16'h2222, 3'd2, 8'h22, 32'h2222_2222};
    send(bmhq_pkg::OP_INSERT, stay, '0);
    stay = {64'd5, 16'h3333, 3'd3, 8'h33, 32'h3333_3333};
    send(bmhq_pkg::OP_INSERT, stay, '0);
    stay = {64'd3, 16'h4444, 3'd4, 8'h44, 32'h4444_4444};
    send(bmhq_pkg::OP_INSERT, stay, '0);
    send(bmhq_pkg::OP_DELETE, random_stay(), '1);
    send(bmhq_pkg::OP_DELETE, random_stay(), bmhq_pkg::PosW'(level));
    send(bmhq_pkg::OP_DELETE, random_stay(), bmhq_pkg::PosW'(level - 1));
    send(bmhq_pkg::OP_NONE, random_stay(), '0);
    send(bmhq_pkg::OP_DELETE, random_stay(), '0);
    send(bmhq_pkg::OP_INSERT, random_stay(), '0);
    repeat (6) send(bmhq_pkg::OP_EXTRACT, random_stay(), '0);
    drain();

    round = 0;
    while (items_sent < TotalItems) begin
      case (round % 4)
        0:       phase = 1;
        2:       phase = 2;
        default: phase = 0;
      endcase
      span = (phase == 0) ? $urandom_range(60, 120) : 180;
      repeat (span) begin
        if (items_sent < TotalItems) send(pick_op(phase), random_stay(), pick_position());
      end
      if ($urandom_range(0, 2) == 0) drain();
      round++;
    end

    drain();
    repeat (40) @(negedge clk);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
